// ----- hw/rtl/pmt_pair_majority_trigger_defines.svh -----
// Assertion macros for the pair-majority trigger.
`ifndef PMT_PAIR_MAJORITY_TRIGGER_DEFINES_SVH
`define PMT_PAIR_MAJORITY_TRIGGER_DEFINES_SVH

`ifndef SYNTH
// Check a property on aclk, skipped while reset is held.
`define PMT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pmt_pair_majority_trigger: assertion failed");
// Check a property on aclk at every edge, reset included.
`define PMT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("pmt_pair_majority_trigger: assertion failed");
`else
`define PMT_ASSERT(label, prop)
`define PMT_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hw/rtl/pmt_pkg.sv -----
// Shared constants and types for the pair-majority trigger.
`default_nettype none

package pmt_pkg;

    // Lane geometry
    localparam int PAIR_LANES   = 50;
    localparam int SINGLE_LANES = 8;
    localparam int DECIMATION   = 4;
    localparam int LANES        = PAIR_LANES + SINGLE_LANES;

    // Input field widths, fixed by the stream format
    localparam int PAIR_FIELD_W   = 50;
    localparam int SINGLE_FIELD_W = 8;
    localparam int S_TDATA_W      = ((2 * PAIR_FIELD_W + SINGLE_FIELD_W + 7) / 8) * 8;

    // Result and state widths
    localparam int IDX_W     = 20;
    localparam int CNT_W     = $clog2(LANES + 1);
    localparam int STRETCH_W = 4;
    localparam int PHASE_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int M_TDATA_W = ((2 * CNT_W + IDX_W + 7) / 8) * 8;

    // Merge tree: lanes are counted in groups of eight
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int LANES_PAD  = GROUPS * GROUP_SIZE;
    localparam int GRP_W      = $clog2(GROUP_SIZE + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAIR_LOGIC_AND   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRETCH_WIDTH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_START_BIN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_END_BIN   = 2'd3;

    // Register reset values
    localparam logic                 RST_PAIR_LOGIC_AND   = 1'b0;
    localparam logic [STRETCH_W-1:0] RST_STRETCH_WIDTH    = 4'd11;
    localparam logic [IDX_W-1:0]     RST_WINDOW_START_BIN = 20'd187500;
    localparam logic [IDX_W-1:0]     RST_WINDOW_END_BIN   = 20'd187700;

    // Per-request side information that follows the lane bits down the pipe
    typedef struct packed {
        logic             window_first;
        logic             window_last;
        logic [IDX_W-1:0] window_offset;
    } pmt_meta_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pmt_lane.sv -----
// One trigger lane: rising-edge detect and pulse stretch.
`default_nettype none

module pmt_lane (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic                          raw,
    input  wire logic [pmt_pkg::STRETCH_W-1:0] stretch_width,
    output logic                               lane_out
);

    logic [pmt_pkg::STRETCH_W-1:0] stretch_left_reg;
    logic [pmt_pkg::STRETCH_W-1:0] stretch_left_next;
    logic                          prev_out_reg;
    logic                          held;
    logic                          out_now;

    // Hold the lane while the stretch counter runs; restart it on a rising edge
    always_comb begin
        held              = (stretch_left_reg != '0);
        out_now           = raw | held;
        stretch_left_next = held ? stretch_left_reg - 1'b1 : stretch_left_reg;
        if (raw && !prev_out_reg) begin
            stretch_left_next = stretch_width;
        end
    end

    // Advance lane state on kept ticks only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stretch_left_reg <= '0;
            prev_out_reg     <= 1'b1;
        end else if (step) begin
            stretch_left_reg <= stretch_left_next;
            prev_out_reg     <= out_now;
        end
    end

    // The last stretched value is the lane's result for the tick just taken
    assign lane_out = prev_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pmt_merge.sv -----
// Lane merge: grouped popcount, total, running peak and output register.
`default_nettype none

module pmt_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pmt_pkg::LANES-1:0]     lanes,
    input  wire pmt_pkg::pmt_meta_t            in_meta,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pmt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    logic [pmt_pkg::LANES_PAD-1:0] lanes_pad;
    logic [pmt_pkg::GRP_W-1:0]     grp_next [pmt_pkg::GROUPS];
    logic [pmt_pkg::GRP_W-1:0]     grp_reg  [pmt_pkg::GROUPS];
    pmt_pkg::pmt_meta_t            meta_reg;
    logic                          grp_valid_reg;
    logic                          grp_ready;
    logic                          out_ready;
    logic                          out_load;

    logic [pmt_pkg::CNT_W-1:0]     total;
    logic [pmt_pkg::CNT_W-1:0]     peak_next;
    logic [pmt_pkg::CNT_W-1:0]     peak_reg;
    logic [pmt_pkg::CNT_W-1:0]     count_reg;
    logic [pmt_pkg::IDX_W-1:0]     offset_reg;
    logic                          last_reg;
    logic                          out_valid_reg;

    // Stage handshakes: a stage takes a request when empty or draining
    assign out_ready = !out_valid_reg || m_tready;
    assign out_load  = grp_valid_reg && out_ready;
    assign grp_ready = !grp_valid_reg || out_ready;
    assign in_ready  = grp_ready;

    // Count each group of eight lanes
    always_comb begin
        lanes_pad = pmt_pkg::LANES_PAD'(lanes);
        for (int g = 0; g < pmt_pkg::GROUPS; g++) begin
            grp_next[g] = '0;
            for (int b = 0; b < pmt_pkg::GROUP_SIZE; b++) begin
                grp_next[g] = grp_next[g]
                    + pmt_pkg::GRP_W'(lanes_pad[g * pmt_pkg::GROUP_SIZE + b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
        end else if (grp_ready) begin
            grp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_ready && in_valid) begin
            grp_reg  <= grp_next;
            meta_reg <= in_meta;
        end
    end

    // Add the group counts and update the peak
    always_comb begin
        total = '0;
        for (int g = 0; g < pmt_pkg::GROUPS; g++) begin
            total = total + pmt_pkg::CNT_W'(grp_reg[g]);
        end
        peak_next = (meta_reg.window_first || total > peak_reg) ? total : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                peak_reg      <= peak_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            count_reg  <= total;
            offset_reg <= meta_reg.window_offset;
            last_reg   <= meta_reg.window_last;
        end
    end

    // Drive the result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pmt_pkg::M_TDATA_W'({offset_reg, peak_reg, count_reg});
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pmt_pair_majority_trigger.sv -----
// Top level of the pair-majority trigger: config, decimation, lanes, merge.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata: first, second, single tube hits
//  m_        out        m_tvalid/m_tready  m_tdata: lanes_on, peak, offset; m_tlast
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wr_data
//
// One raw tick is taken per cycle while s_tready is high; the block sustains a tick every clock unless m_tready stalls.
// A kept tick in the window raises m_tvalid through the lane register (loaded at the edge that takes it),
// then the group-count register, then the output register.
// Reset is synchronous on aresetn; no clearing pass is needed.
// A stalled m_tready backs up the three stages, then drops s_tready.
`default_nettype none

`include "pmt_pair_majority_trigger_defines.svh"

module pmt_pair_majority_trigger (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // first_tube_hits[49:0], second_tube_hits[99:50], single_tube_hits[107:100]
    input  wire logic [pmt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // lanes_on[5:0], peak_lanes_on[11:6], window_offset[31:12]
    output logic [pmt_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pmt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pmt_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    logic                          pair_and_reg;
    logic [pmt_pkg::STRETCH_W-1:0] stretch_width_reg;
    logic [pmt_pkg::IDX_W-1:0]     win_start_reg;
    logic [pmt_pkg::IDX_W-1:0]     win_end_reg;

    logic [pmt_pkg::PHASE_W-1:0]   phase_reg;
    logic [pmt_pkg::PHASE_W-1:0]   phase_next;
    logic [pmt_pkg::IDX_W-1:0]     tick_idx_reg;
    logic                          s_fire;
    logic                          kept;
    logic                          step;
    logic                          in_window;
    pmt_pkg::pmt_meta_t            meta_next;
    pmt_pkg::pmt_meta_t            meta_reg;
    logic                          lane_valid_reg;
    logic                          merge_ready;

    logic [pmt_pkg::LANES-1:0]     raw;
    logic [pmt_pkg::LANES-1:0]     lane_bits;

    logic [pmt_pkg::CNT_W-1:0]     chk_count;
    logic [pmt_pkg::CNT_W-1:0]     chk_peak;
    logic [pmt_pkg::IDX_W-1:0]     chk_offset;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_and_reg      <= pmt_pkg::RST_PAIR_LOGIC_AND;
            stretch_width_reg <= pmt_pkg::RST_STRETCH_WIDTH;
            win_start_reg     <= pmt_pkg::RST_WINDOW_START_BIN;
            win_end_reg       <= pmt_pkg::RST_WINDOW_END_BIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pmt_pkg::CFG_PAIR_LOGIC_AND: begin
                    pair_and_reg <= cfg_wr_data[0];
                end
                pmt_pkg::CFG_STRETCH_WIDTH: begin
                    stretch_width_reg <= cfg_wr_data[pmt_pkg::STRETCH_W-1:0];
                end
                pmt_pkg::CFG_WINDOW_START_BIN: begin
                    win_start_reg <= cfg_wr_data[pmt_pkg::IDX_W-1:0];
                end
                pmt_pkg::CFG_WINDOW_END_BIN: begin
                    win_end_reg <= cfg_wr_data[pmt_pkg::IDX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Decimate: keep the first tick of every group
    assign s_tready = !lane_valid_reg || merge_ready;
    assign s_fire   = s_tvalid && s_tready;
    assign kept     = (phase_reg == '0);
    assign step     = s_fire && kept;

    always_comb begin
        if (phase_reg == pmt_pkg::PHASE_W'(pmt_pkg::DECIMATION - 1)) begin
            phase_next = '0;
        end else begin
            phase_next = phase_reg + 1'b1;
        end
    end

    // Classify the kept tick against the window
    always_comb begin
        in_window               = (tick_idx_reg >= win_start_reg)
                                  && (tick_idx_reg < win_end_reg);
        meta_next.window_first  = (tick_idx_reg == win_start_reg);
        meta_next.window_last   = (tick_idx_reg == win_end_reg - 1'b1);
        meta_next.window_offset = tick_idx_reg - win_start_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            tick_idx_reg   <= '0;
            lane_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg <= phase_next;
            end
            if (step) begin
                tick_idx_reg <= tick_idx_reg + 1'b1;
            end
            if (s_tready) begin
                lane_valid_reg <= step && in_window;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            meta_reg <= meta_next;
        end
    end

    // Combine tube pairs and pass single tubes through
    for (genvar k = 0; k < pmt_pkg::PAIR_LANES; k++) begin : g_pair_raw
        assign raw[k] = pair_and_reg
            ? (s_tdata[k] & s_tdata[pmt_pkg::PAIR_FIELD_W + k])
            : (s_tdata[k] | s_tdata[pmt_pkg::PAIR_FIELD_W + k]);
    end
    for (genvar k = 0; k < pmt_pkg::SINGLE_LANES; k++) begin : g_single_raw
        assign raw[pmt_pkg::PAIR_LANES + k] = s_tdata[2 * pmt_pkg::PAIR_FIELD_W + k];
    end

    // Lanes run side by side
    for (genvar k = 0; k < pmt_pkg::LANES; k++) begin : g_lane
        pmt_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .step          (step),
            .raw           (raw[k]),
            .stretch_width (stretch_width_reg),
            .lane_out      (lane_bits[k])
        );
    end

    // Merge lane results into count and peak
    pmt_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (lane_valid_reg),
        .in_ready (merge_ready),
        .lanes    (lane_bits),
        .in_meta  (meta_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Split the result fields for the checks
    assign chk_count  = m_tdata[pmt_pkg::CNT_W-1:0];
    assign chk_peak   = m_tdata[2*pmt_pkg::CNT_W-1:pmt_pkg::CNT_W];
    assign chk_offset = m_tdata[2*pmt_pkg::CNT_W +: pmt_pkg::IDX_W];

    // Checks
    `PMT_ASSERT(a_peak_covers_count, m_tvalid |-> (chk_peak >= chk_count))
    `PMT_ASSERT(a_count_in_range,
        m_tvalid |-> (chk_count <= pmt_pkg::CNT_W'(pmt_pkg::LANES)))
    `PMT_ASSERT(a_window_start_resets_peak,
        (m_tvalid && chk_offset == '0) |-> (chk_peak == chk_count))
    `PMT_ASSERT(a_dropped_tick_no_request,
        (s_fire && !kept) |=> !lane_valid_reg)
    `PMT_ASSERT_ALWAYS(a_reset_clears_output,
        !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire
